>>> sv/ldf_pkg.sv
package ldf_pkg;

  // Packet framing
  localparam int HEADER_BYTES = 8;
  localparam int TAIL_BYTES   = 4;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

  // Field widths
  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;
  localparam int OFS_W  = 33;
  localparam int HOLD_W = (HEADER_BYTES - 1) * BYTE_W;

  typedef enum logic [0:0] {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [WORD_W-1:0] message_type;
    logic [WORD_W-1:0] body_bytes;
    logic [OFS_W-1:0]  byte_offset;
    logic              has_bytes;
    logic              last;
  } result_t;

endpackage

>>> sv/ldf_stream_if.sv
interface ldf_stream_if
  import ldf_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

>>> sv/ldf_record_if.sv
interface ldf_record_if
  import ldf_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [WORD_W-1:0] message_type;
  logic [WORD_W-1:0] body_bytes;
  logic [OFS_W-1:0]  byte_offset;
  logic              has_bytes;
  logic              last;

  modport source (output valid, output data_byte, output message_type, output body_bytes,
                  output byte_offset, output has_bytes, output last, input ready);
  modport sink   (input valid, input data_byte, input message_type, input body_bytes,
                  input byte_offset, input has_bytes, input last, output ready);
endinterface

>>> sv/length_prefixed_deframer_core.sv
// Length-prefixed packet deframer.
// stream (sink): one received byte per request, valid/ready handshake.
// record (source): one tagged byte record per request (byte, type, length,
//   offset within the packet, has_bytes, last).
// A packet is an 8-byte header (big-endian type, then big-endian body length),
// the body and a 4-byte checksum tail passed through unchecked.
// Header bytes are held until the eighth arrives; for a non-empty body the
// header is then replayed from the decoded type/length, one record per cycle
// unless the receiver stalls. A body or tail byte of a non-empty packet is
// registered onto record in the cycle after it is taken. The stream takes one
// byte per cycle unless stalled, and is held off while a header replay drains.
// A zero-length packet gives a single empty record with its final tail byte.
// A stalled receiver holds the output register; a new byte is still taken in
// the cycle the waiting record leaves. Reset (rst, synchronous) returns to
// header collection with no record pending.
module length_prefixed_deframer_core
  import ldf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ldf_stream_if.sink   stream,
  ldf_record_if.source record
);

  localparam logic [OFS_W-1:0] FINAL_BASE = OFS_W'(HEADER_BYTES + TAIL_BYTES - 1);
  localparam logic [OFS_W-1:0] HDR_LAST   = OFS_W'(HEADER_BYTES - 1);
  localparam logic [OFS_W-1:0] HDR_COUNT  = OFS_W'(HEADER_BYTES);
  localparam logic [HDR_IDX_W-1:0] IDX_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

  phase_t               phase, phase_next;
  logic [HOLD_W-1:0]    header_hold, header_hold_next;
  logic [OFS_W-1:0]     packet_count, packet_count_next;
  logic [WORD_W-1:0]    held_type, held_type_next;
  logic [WORD_W-1:0]    held_length, held_length_next;
  logic [OFS_W-1:0]     final_off, final_off_next;
  logic                 replaying, replaying_next;
  logic [HDR_IDX_W-1:0] replay_idx, replay_idx_next;
  logic                 rec_valid;
  result_t              rec, rec_next;
  logic                 rec_load;

  logic                       slot_free, stream_fire, replay_step, fin;
  logic [2*WORD_W-1:0]        full_hdr, held_hdr;
  logic [$clog2(2*WORD_W)-1:0] replay_base;

  // Output slot frees when empty or being taken
  assign slot_free    = !rec_valid || record.ready;
  assign stream.ready = !replaying && slot_free;
  assign stream_fire  = stream.valid && stream.ready;
  assign replay_step  = replaying && slot_free;

  assign full_hdr    = {header_hold, stream.stream_byte};
  assign held_hdr    = {held_type, held_length};
  assign replay_base = {~replay_idx, 3'b000};
  assign fin         = packet_count >= final_off;

  // Next state and record
  always_comb begin
    phase_next        = phase;
    header_hold_next  = header_hold;
    packet_count_next = packet_count;
    held_type_next    = held_type;
    held_length_next  = held_length;
    final_off_next    = final_off;
    replaying_next    = replaying;
    replay_idx_next   = replay_idx;
    rec_next          = rec;
    rec_load          = 1'b0;

    if (replay_step) begin
      // Header replay from the decoded registers
      rec_load              = 1'b1;
      rec_next.data_byte    = held_hdr[replay_base +: BYTE_W];
      rec_next.message_type = held_type;
      rec_next.body_bytes   = held_length;
      rec_next.byte_offset  = OFS_W'(replay_idx);
      rec_next.has_bytes    = 1'b1;
      rec_next.last         = 1'b0;
      replay_idx_next       = replay_idx + 1'b1;
      if (replay_idx == IDX_LAST) begin
        replaying_next = 1'b0;
      end
    end else if (stream_fire) begin
      if (phase == PH_HEADER) begin
        if (packet_count < HDR_LAST) begin
          header_hold_next  = {header_hold[HOLD_W-BYTE_W-1:0], stream.stream_byte};
          packet_count_next = packet_count + 1'b1;
        end else begin
          // Header complete: decode, and start replay if the body is non-empty
          held_type_next   = full_hdr[2*WORD_W-1:WORD_W];
          held_length_next = full_hdr[WORD_W-1:0];
          header_hold_next = '0;
          final_off_next   = FINAL_BASE + {1'b0, full_hdr[WORD_W-1:0]};
          if (full_hdr[WORD_W-1:0] != '0) begin
            rec_load              = 1'b1;
            rec_next.data_byte    = full_hdr[2*WORD_W-1 -: BYTE_W];
            rec_next.message_type = full_hdr[2*WORD_W-1:WORD_W];
            rec_next.body_bytes   = full_hdr[WORD_W-1:0];
            rec_next.byte_offset  = '0;
            rec_next.has_bytes    = 1'b1;
            rec_next.last         = 1'b0;
            replaying_next        = 1'b1;
            replay_idx_next       = HDR_IDX_W'(1);
          end
          if (full_hdr[WORD_W-1:0] == '0 && TAIL_BYTES == 0) begin
            // Empty packet with no tail ends here
            rec_load              = 1'b1;
            rec_next.data_byte    = '0;
            rec_next.message_type = full_hdr[2*WORD_W-1:WORD_W];
            rec_next.body_bytes   = '0;
            rec_next.byte_offset  = '0;
            rec_next.has_bytes    = 1'b0;
            rec_next.last         = 1'b1;
            packet_count_next     = '0;
          end else begin
            packet_count_next = HDR_COUNT;
            phase_next        = PH_BODY;
          end
        end
      end else begin
        // Body and tail bytes
        rec_next.message_type = held_type;
        rec_next.body_bytes   = held_length;
        rec_next.last         = fin;
        if (held_length != '0) begin
          rec_load             = 1'b1;
          rec_next.data_byte   = stream.stream_byte;
          rec_next.byte_offset = packet_count;
          rec_next.has_bytes   = 1'b1;
        end else if (fin) begin
          rec_load             = 1'b1;
          rec_next.data_byte   = '0;
          rec_next.byte_offset = '0;
          rec_next.has_bytes   = 1'b0;
        end
        if (fin) begin
          packet_count_next = '0;
          phase_next        = PH_HEADER;
        end else begin
          packet_count_next = packet_count + 1'b1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      packet_count <= '0;
      held_type    <= '0;
      held_length  <= '0;
      replaying    <= 1'b0;
      replay_idx   <= '0;
      rec_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      packet_count <= packet_count_next;
      held_type    <= held_type_next;
      held_length  <= held_length_next;
      replaying    <= replaying_next;
      replay_idx   <= replay_idx_next;
      if (rec_load) begin
        rec_valid <= 1'b1;
      end else if (record.ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    header_hold <= header_hold_next;
    final_off   <= final_off_next;
    rec         <= rec_next;
  end

  assign record.valid        = rec_valid;
  assign record.data_byte    = rec.data_byte;
  assign record.message_type = rec.message_type;
  assign record.body_bytes   = rec.body_bytes;
  assign record.byte_offset  = rec.byte_offset;
  assign record.has_bytes    = rec.has_bytes;
  assign record.last         = rec.last;

endmodule
